>>> rtl/fpec_pkg.sv
// ----------------------------------------------------------------------------
// Flash program/erase controller package
// Shared types, register offsets, unlock keys and sizes for the controller.
// ----------------------------------------------------------------------------
package fpec_pkg;

  localparam int FLASH_WORDS = 1024;
  localparam int PAGE_WORDS  = 64;
  localparam int WORD_AW     = $clog2(FLASH_WORDS);
  localparam int PAGE_AW     = $clog2(PAGE_WORDS);
  localparam int CNT_W       = 12;
  localparam int PTICK_W     = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 12;

  localparam logic [2:0] ACT_REG_WRITE   = 3'd0;
  localparam logic [2:0] ACT_REG_READ    = 3'd1;
  localparam logic [2:0] ACT_FLASH_WRITE = 3'd2;
  localparam logic [2:0] ACT_FLASH_READ  = 3'd3;
  localparam logic [2:0] ACT_TICK        = 3'd4;

  localparam logic [2:0] REG_ACR     = 3'd0;
  localparam logic [2:0] REG_PECR    = 3'd1;
  localparam logic [2:0] REG_PEKEYR  = 3'd3;
  localparam logic [2:0] REG_PRGKEYR = 3'd4;
  localparam logic [2:0] REG_SR      = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_TICKS   = 1'd1;

  localparam logic [31:0] KEY_PE1  = 32'h89AB_CDEF;
  localparam logic [31:0] KEY_PE2  = 32'h0203_0405;
  localparam logic [31:0] KEY_PRG1 = 32'h8C9D_AEBF;
  localparam logic [31:0] KEY_PRG2 = 32'h1314_1516;

  localparam logic [1:0] MODE_ERASE = 2'b11;

  typedef struct packed {
    logic [2:0]         action;
    logic [2:0]         reg_index;
    logic [WORD_AW-1:0] word_index;
    logic [31:0]        write_data;
  } fpec_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        busy_res;
  } fpec_rsp_t;

  typedef struct packed {
    logic sizerr;
    logic pgaerr;
    logic wrperr;
    logic eop;
    logic busy;
  } fpec_flags_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic clear_step;
    logic erase_step;
  } fpec_cmd_t;

  typedef struct packed {
    logic erase_go;
    logic clear_last;
    logic page_last;
  } fpec_stat_t;

endpackage

>>> rtl/flash_program_erase_controller_top.sv
// ----------------------------------------------------------------------------
// Flash program/erase controller
// Bus-level model of a flash controller with two-stage key unlock, word
// program, page erase, busy countdown and write-one-to-clear status.
// ----------------------------------------------------------------------------
// Each request transaction on req is one bus access: a register write or
// read, a flash word write or read, or one tick of time. Every request gives
// exactly one response transaction on rsp, in order, carrying the read value
// and the busy flag after the access.
// A request is captured together with its array read data, and then, once the
// output register is free, the register state is combined with it and the
// response is loaded into the output register. A page erase then zeroes the
// page one word per cycle through the single write port of the array, so an
// erase request holds req_stall until the last word of the page is zeroed.
// After reset the array is cleared one word per cycle with req_stall high;
// the tick settings port (cfg) is always ready.
// While rsp is stalled the response is held and one more request can be
// captured; its response waits until the output register is free.
// ----------------------------------------------------------------------------
module flash_program_erase_controller_top
  import fpec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  fpec_req_t             req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output fpec_rsp_t             rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fpec_cmd_t  cmd;
  fpec_stat_t stat;

  assign cfg_ready = 1'b1;

  fpec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fpec_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

>>> rtl/fpec_ctrl.sv
// ----------------------------------------------------------------------------
// Flash program/erase controller sequencer
// Walks each transaction through accept and execute steps, adds a page sweep
// step for a page erase, and runs the array clearing pass after reset.
// ----------------------------------------------------------------------------
module fpec_ctrl
  import fpec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  fpec_stat_t stat,
  output fpec_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_ERASE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid && rsp_stall;
    cmd            = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd.exec       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = stat.erase_go ? ST_ERASE : ST_IDLE;
        end
      end
      ST_ERASE: begin
        cmd.erase_step = 1'b1;
        if (stat.page_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

>>> rtl/fpec_datapath.sv
// ----------------------------------------------------------------------------
// Flash program/erase controller datapath
// Holds the lock and key state, the status flags, the busy countdown, the
// tick settings, the flash array and the response register.
// ----------------------------------------------------------------------------
module fpec_datapath
  import fpec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  fpec_cmd_t             cmd,
  output fpec_stat_t            stat,
  input  fpec_req_t             req,
  output fpec_rsp_t             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [31:0]        mem [FLASH_WORDS];
  logic [31:0]        mem_rdata;
  logic               mem_we;
  logic [WORD_AW-1:0] mem_waddr;
  logic [31:0]        mem_wdata;

  fpec_req_t          item;
  logic [WORD_AW-1:0] sweep_addr;

  logic [PTICK_W-1:0] program_ticks;
  logic [CNT_W-1:0]   erase_ticks;

  logic               control_locked, control_locked_next;
  logic               program_locked, program_locked_next;
  logic               control_key_stage, control_key_stage_next;
  logic               program_key_stage, program_key_stage_next;
  logic [1:0]         mode_bits, mode_bits_next;
  logic [2:0]         acr, acr_next;
  fpec_flags_t        flags, flags_next;
  logic [CNT_W-1:0]   countdown, countdown_next;
  logic [CNT_W-1:0]   count_dec;
  logic [CNT_W-1:0]   program_load;
  logic [CNT_W-1:0]   erase_load;
  logic [31:0]        read_value;
  logic               program_go;
  logic               write_ok;

  assign program_load = (program_ticks == '0) ? CNT_W'(1) : CNT_W'(program_ticks);
  assign erase_load   = (erase_ticks == '0) ? CNT_W'(1) : erase_ticks;
  assign count_dec    = (countdown != '0) ? countdown - CNT_W'(1) : countdown;

  assign write_ok   = (item.action == ACT_FLASH_WRITE) && !control_locked &&
                      !program_locked && !flags.busy;
  assign program_go = write_ok && (mode_bits != MODE_ERASE);

  assign stat.erase_go   = write_ok && (mode_bits == MODE_ERASE);
  assign stat.clear_last = &sweep_addr;
  assign stat.page_last  = &sweep_addr[PAGE_AW-1:0];

  always_comb begin
    control_locked_next    = control_locked;
    program_locked_next    = program_locked;
    control_key_stage_next = control_key_stage;
    program_key_stage_next = program_key_stage;
    mode_bits_next         = mode_bits;
    acr_next               = acr;
    flags_next             = flags;
    countdown_next         = countdown;
    read_value             = '0;
    case (item.action)
      ACT_REG_WRITE: begin
        case (item.reg_index)
          REG_ACR: begin
            acr_next = item.write_data[2:0];
          end
          REG_PECR: begin
            if (!control_locked) begin
              mode_bits_next = {item.write_data[9], item.write_data[3]};
              if (item.write_data[1]) begin
                program_locked_next    = 1'b1;
                program_key_stage_next = 1'b0;
              end
              if (item.write_data[0]) begin
                control_locked_next    = 1'b1;
                program_locked_next    = 1'b1;
                control_key_stage_next = 1'b0;
                program_key_stage_next = 1'b0;
              end
            end
          end
          REG_PEKEYR: begin
            if (control_locked) begin
              if (!control_key_stage) begin
                control_key_stage_next = (item.write_data == KEY_PE1);
              end else begin
                if (item.write_data == KEY_PE2) begin
                  control_locked_next = 1'b0;
                end
                control_key_stage_next = 1'b0;
              end
            end
          end
          REG_PRGKEYR: begin
            if (!control_locked && program_locked) begin
              if (!program_key_stage) begin
                program_key_stage_next = (item.write_data == KEY_PRG1);
              end else begin
                if (item.write_data == KEY_PRG2) begin
                  program_locked_next = 1'b0;
                end
                program_key_stage_next = 1'b0;
              end
            end
          end
          REG_SR: begin
            flags_next.eop    = flags.eop && !item.write_data[1];
            flags_next.wrperr = flags.wrperr && !item.write_data[8];
            flags_next.pgaerr = flags.pgaerr && !item.write_data[9];
            flags_next.sizerr = flags.sizerr && !item.write_data[10];
          end
          default: begin
          end
        endcase
      end
      ACT_REG_READ: begin
        case (item.reg_index)
          REG_ACR: begin
            read_value = {29'd0, acr};
          end
          REG_PECR: begin
            read_value = {22'd0, mode_bits[1], 5'd0, mode_bits[0], 1'b0,
                          program_locked, control_locked};
          end
          REG_SR: begin
            read_value = {21'd0, flags.sizerr, flags.pgaerr, flags.wrperr, 6'd0,
                          flags.eop, flags.busy};
          end
          default: begin
            read_value = '0;
          end
        endcase
      end
      ACT_FLASH_WRITE: begin
        if (control_locked || program_locked) begin
          flags_next.wrperr = 1'b1;
        end else if (!flags.busy) begin
          flags_next.busy = 1'b1;
          countdown_next  = (mode_bits == MODE_ERASE) ? erase_load : program_load;
        end
      end
      ACT_FLASH_READ: begin
        read_value = mem_rdata;
      end
      ACT_TICK: begin
        if (flags.busy) begin
          countdown_next = count_dec;
          if (count_dec == '0) begin
            flags_next.busy = 1'b0;
            flags_next.eop  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we    = cmd.clear_step || cmd.erase_step;
    mem_waddr = sweep_addr;
    mem_wdata = '0;
    if (cmd.exec && program_go) begin
      mem_we    = 1'b1;
      mem_waddr = item.word_index;
      mem_wdata = item.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.accept) begin
      mem_rdata <= mem[req.word_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= req;
    end
    if (cmd.exec) begin
      rsp.read_data <= read_value;
      rsp.busy_res  <= flags_next.busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.exec && stat.erase_go) begin
      sweep_addr <= {item.word_index[WORD_AW-1:PAGE_AW], {PAGE_AW{1'b0}}};
    end else if (cmd.clear_step || cmd.erase_step) begin
      sweep_addr <= sweep_addr + WORD_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_ticks <= PTICK_W'(4);
      erase_ticks   <= CNT_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROGRAM_TICKS: program_ticks <= cfg_data[PTICK_W-1:0];
        CFG_ERASE_TICKS:   erase_ticks   <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_locked    <= 1'b1;
      program_locked    <= 1'b1;
      control_key_stage <= 1'b0;
      program_key_stage <= 1'b0;
      mode_bits         <= '0;
      acr               <= '0;
      flags             <= '0;
      countdown         <= '0;
    end else if (cmd.exec) begin
      control_locked    <= control_locked_next;
      program_locked    <= program_locked_next;
      control_key_stage <= control_key_stage_next;
      program_key_stage <= program_key_stage_next;
      mode_bits         <= mode_bits_next;
      acr               <= acr_next;
      flags             <= flags_next;
      countdown         <= countdown_next;
    end
  end

endmodule

>>> rtl/fpec_checker.sv
// ----------------------------------------------------------------------------
// Flash program/erase controller checker
// Port-level checks on the request and response channels of the controller.
// ----------------------------------------------------------------------------
module fpec_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("A stalled response transaction was withdrawn.");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("A request was not stalled during the clearing pass.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("Two request transactions were taken in consecutive cycles.");

  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
    else $error("A response transaction appeared without a request.");

endmodule

bind flash_program_erase_controller_top fpec_checker u_fpec_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall)
);
